// ----- hdl/gha_pkg.sv -----
// shared types, codes and field widths of the generational handle allocator
package gha_pkg;

  // pool and generation defaults
  localparam int unsigned POOL_SIZE_DEF = 1024;
  localparam int unsigned GEN_BITS_DEF  = 32;

  // fixed payload widths
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned HIDX_W    = 16;
  localparam int unsigned HGEN_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned NIDX_W    = 10;
  localparam int unsigned NGEN_W    = 32;
  localparam int unsigned COUNT_W   = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_CHECK   = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

endpackage

// ----- hdl/gha_if.sv -----
// request and response channel interfaces of the handle allocator
interface gha_req_if;
  import gha_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [HIDX_W-1:0] handle_index;
  logic [HGEN_W-1:0] handle_generation;

  modport source (output valid, output req_type, output handle_index,
                  output handle_generation, input ready);
  modport sink   (input valid, input req_type, input handle_index,
                  input handle_generation, output ready);
endinterface

interface gha_rsp_if;
  import gha_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NIDX_W-1:0]   new_index;
  logic [NGEN_W-1:0]   new_generation;
  logic [COUNT_W-1:0]  living_count;
  logic                pool_full;

  modport source (output valid, output status, output new_index,
                  output new_generation, output living_count,
                  output pool_full, input ready);
  modport sink   (input valid, input status, input new_index,
                  input new_generation, input living_count,
                  input pool_full, output ready);
endinterface

// ----- hdl/generational_handle_allocator.sv -----
// top level of the generational handle allocator
//
// Hands out handles (slot index plus generation) from a pool of POOL_SIZE
// slots and answers destroy and check requests, one response per request.
// A request is taken every cycle when the response side keeps up. The
// request transfer loads the read stage and starts the registered ram
// reads; the decision is then stored in the response register as soon
// as that register is free, and the response is valid from there on.
// Two rams hold the state: the free stack, whose entries carry a slot index
// together with that slot's current generation so a create needs a single
// read, and the slot table with an alive bit and generation per slot. Both
// get one read when a request is taken and at most one write when it is
// decided; a write that hits the address the next request reads is
// forwarded. No
// clearing pass is needed after reset: a low-water mark of the stack
// pointer marks the region never touched, where the stack reads its own
// position and the slot table reads dead with generation zero, so the block
// takes requests straight out of reset. A stalled response holds the
// decided request, and one more request waits in the read stage behind it.
module generational_handle_allocator #(
  parameter int unsigned POOL_SIZE = gha_pkg::POOL_SIZE_DEF,
  parameter int unsigned GEN_BITS  = gha_pkg::GEN_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);

  import gha_pkg::*;

  localparam int unsigned IDXW = $clog2(POOL_SIZE);
  localparam int unsigned CNTW = $clog2(POOL_SIZE + 1);
  localparam int unsigned SW   = IDXW + GEN_BITS;   // free stack entry
  localparam int unsigned TW   = 1 + GEN_BITS;      // slot table entry

  // pool state
  logic [CNTW-1:0] free_top_q, free_top_d;
  logic [CNTW-1:0] wmark_q, wmark_d;
  logic [CNTW-1:0] live_q, live_d;

  // read stage
  logic                s1_valid_q;
  logic [REQ_W-1:0]    s1_req_q;
  logic [HIDX_W-1:0]   s1_idx_q;
  logic [HGEN_W-1:0]   s1_gen_q;
  logic                s1_inrange_q;
  logic                slot_alt_q;
  logic [TW-1:0]       slot_alt_data_q;
  logic                stk_alt_q;
  logic [SW-1:0]       stk_alt_data_q;

  // response register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [NIDX_W-1:0]   out_index_q;
  logic [NGEN_W-1:0]   out_gen_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_full_q;

  // ram ports
  logic            slot_we, stk_we;
  logic [IDXW-1:0] slot_waddr, stk_waddr, slot_raddr, stk_raddr;
  logic [TW-1:0]   slot_wdata, slot_rdata;
  logic [SW-1:0]   stk_wdata, stk_rdata;

  // handshake
  logic out_take, s1_go, in_ready, in_fire;

  // decision
  logic [TW-1:0]        slot_data;
  logic [SW-1:0]        stk_data;
  logic                 slot_alive;
  logic [GEN_BITS-1:0]  slot_gen, pop_gen, inc_gen;
  logic [IDXW-1:0]      pop_slot;
  logic                 handle_ok;
  status_e              status;
  logic [IDXW-1:0]      nidx;
  logic [GEN_BITS-1:0]  ngen;

  // accept side
  logic [CNTW-1:0] pop_pos;
  logic            in_range;
  logic [31:0]     nidx_ext, count_ext;

  assign out_take = !out_valid_q || rsp_o.ready;
  assign s1_go    = s1_valid_q && out_take;
  assign in_ready = !s1_valid_q || out_take;
  assign in_fire  = req_i.valid && in_ready;

  // ---------------------------------------------------------------------
  // state rams
  // ---------------------------------------------------------------------
  gha_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE), .AW(IDXW)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_fire),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  gha_ram #(.WIDTH(TW), .DEPTH(POOL_SIZE), .AW(IDXW)) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (in_fire),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // ---------------------------------------------------------------------
  // decision stage: request in the read stage meets its ram data
  // ---------------------------------------------------------------------
  assign slot_data  = slot_alt_q ? slot_alt_data_q : slot_rdata;
  assign stk_data   = stk_alt_q ? stk_alt_data_q : stk_rdata;
  assign slot_alive = slot_data[GEN_BITS];
  assign slot_gen   = slot_data[GEN_BITS-1:0];
  assign pop_slot   = stk_data[SW-1:GEN_BITS];
  assign pop_gen    = stk_data[GEN_BITS-1:0];
  assign inc_gen    = pop_gen + 1'b1;

  // generation bits above GEN_BITS never match a stored generation
  assign handle_ok = s1_inrange_q && slot_alive && (32'(slot_gen) == s1_gen_q);

  always_comb begin
    status     = ST_INVALID;
    nidx       = '0;
    ngen       = '0;
    free_top_d = free_top_q;
    wmark_d    = wmark_q;
    live_d     = live_q;
    slot_we    = 1'b0;
    slot_waddr = s1_idx_q[IDXW-1:0];
    slot_wdata = {1'b0, slot_gen};
    stk_we     = 1'b0;
    stk_waddr  = free_top_q[IDXW-1:0];
    stk_wdata  = {s1_idx_q[IDXW-1:0], slot_gen};
    if (s1_go) begin
      unique case (s1_req_q)
        REQ_CREATE: begin
          if (live_q >= CNTW'(POOL_SIZE) || free_top_q == '0) begin
            status = ST_FULL;
          end else begin
            status     = ST_OK;
            nidx       = pop_slot;
            ngen       = inc_gen;
            free_top_d = free_top_q - 1'b1;
            live_d     = live_q + 1'b1;
            if (free_top_d < wmark_q) begin
              wmark_d = free_top_d;
            end
            slot_we    = 1'b1;
            slot_waddr = pop_slot;
            slot_wdata = {1'b1, inc_gen};
          end
        end
        REQ_DESTROY: begin
          if (handle_ok && free_top_q < CNTW'(POOL_SIZE)) begin
            status     = ST_OK;
            slot_we    = 1'b1;
            stk_we     = 1'b1;
            free_top_d = free_top_q + 1'b1;
            if (live_q != '0) begin
              live_d = live_q - 1'b1;
            end
          end
        end
        REQ_CHECK: begin
          status = handle_ok ? ST_OK : ST_INVALID;
        end
        default: begin
          status = ST_INVALID;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // accept side: ram addresses follow the state the decision leaves
  // ---------------------------------------------------------------------
  assign pop_pos    = free_top_d - 1'b1;
  assign stk_raddr  = pop_pos[IDXW-1:0];
  assign slot_raddr = req_i.handle_index[IDXW-1:0];
  assign in_range   = 32'(req_i.handle_index) < POOL_SIZE;
  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      free_top_q <= CNTW'(POOL_SIZE);
      wmark_q    <= CNTW'(POOL_SIZE);
      live_q     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= req_i.valid;
      end
      free_top_q <= free_top_d;
      wmark_q    <= wmark_d;
      live_q     <= live_d;
    end
  end

  // payload of the read stage, with forwarding and the untouched region
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q     <= req_i.req_type;
      s1_idx_q     <= req_i.handle_index;
      s1_gen_q     <= req_i.handle_generation;
      s1_inrange_q <= in_range;
      // a push by the decided request lands exactly where the next pop reads
      if (stk_we) begin
        stk_alt_q      <= 1'b1;
        stk_alt_data_q <= stk_wdata;
      end else if (pop_pos < wmark_d) begin
        stk_alt_q      <= 1'b1;
        stk_alt_data_q <= {pop_pos[IDXW-1:0], {GEN_BITS{1'b0}}};
      end else begin
        stk_alt_q      <= 1'b0;
        stk_alt_data_q <= stk_wdata;
      end
      if (slot_we && slot_waddr == slot_raddr) begin
        slot_alt_q      <= 1'b1;
        slot_alt_data_q <= slot_wdata;
      end else if (32'(req_i.handle_index) < 32'(wmark_d)) begin
        // slot never handed out: dead, generation zero
        slot_alt_q      <= 1'b1;
        slot_alt_data_q <= '0;
      end else begin
        slot_alt_q      <= 1'b0;
        slot_alt_data_q <= slot_wdata;
      end
    end
  end

  // ---------------------------------------------------------------------
  // response register
  // ---------------------------------------------------------------------
  assign nidx_ext  = 32'(nidx);
  assign count_ext = 32'(live_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_status_q <= status;
      out_index_q  <= nidx_ext[NIDX_W-1:0];
      out_gen_q    <= 32'(ngen);
      out_count_q  <= count_ext[COUNT_W-1:0];
      out_full_q   <= (live_d == CNTW'(POOL_SIZE));
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.new_index      = out_index_q;
  assign rsp_o.new_generation = out_gen_q;
  assign rsp_o.living_count   = out_count_q;
  assign rsp_o.pool_full      = out_full_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // every slot is either on the free stack or alive
  a_pool_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(live_q) + 32'(free_top_q)) == POOL_SIZE)
    else $error("live count and free stack depth do not add up to the pool");

  // the untouched region always lies below the stack pointer
  a_wmark_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wmark_q <= free_top_q)
    else $error("low-water mark above the free stack pointer");

  // a full response always comes with the full flag
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> rsp_o.pool_full)
    else $error("pool full status without full flag");

  // a request transfer reaches the decision stage in the next cycle
  a_req_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted request lost before decision");

endmodule

// ----- hdl/gha_ram.sv -----
// simple dual-port ram, one write and one registered read port
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/gha_handle_checker.sv -----
`timescale 1ns / 100ps
// response checker for the handle allocator: shadow allocator, queue of awaited responses
module gha_handle_checker #(
  parameter int unsigned POOL_SIZE = gha_pkg::POOL_SIZE_DEF,
  parameter int unsigned GEN_BITS  = gha_pkg::GEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gha_req_if          req_i,
  gha_rsp_if          rsp_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  import gha_pkg::*;

  localparam logic [63:0] GEN_MASK = (64'd1 << GEN_BITS) - 64'd1;

  typedef struct packed {
    status_e            status;
    logic [NIDX_W-1:0]  new_index;
    logic [NGEN_W-1:0]  new_generation;
    logic [COUNT_W-1:0] living_count;
    logic               pool_full;
  } alloc_rsp_t;

  // shadow of the allocator state
  int unsigned free_slots [POOL_SIZE];
  int unsigned free_depth;
  logic [31:0] slot_gen   [POOL_SIZE];
  bit          slot_live  [POOL_SIZE];
  int unsigned live_count;

  alloc_rsp_t  awaited_q [$];

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns  %s", $time, msg);
    error_count_o++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("%s mismatch  got 0x%0h  want 0x%0h", name, got, want));
  endtask

  function automatic bit handle_live(input logic [HIDX_W-1:0] idx,
                                     input logic [HGEN_W-1:0] gen);
    if (idx >= POOL_SIZE) return 1'b0;
    return slot_live[idx] && (slot_gen[idx] == gen);
  endfunction

  // applies one request to the shadow and returns the response it must cause
  function automatic alloc_rsp_t resolve_request(input logic [REQ_W-1:0]  kind,
                                                 input logic [HIDX_W-1:0] idx,
                                                 input logic [HGEN_W-1:0] gen);
    alloc_rsp_t  r;
    int unsigned slot;
    r = '0;
    r.status = ST_INVALID;
    case (kind)
      REQ_CREATE: begin
        if (live_count >= POOL_SIZE || free_depth == 0) begin
          r.status = ST_FULL;
        end else begin
          free_depth--;
          slot = free_slots[free_depth];
          if (slot >= POOL_SIZE) slot = 0;
          slot_live[slot] = 1'b1;
          slot_gen[slot]  = 32'((64'(slot_gen[slot]) + 64'd1) & GEN_MASK);
          live_count++;
          r.status         = ST_OK;
          r.new_index      = NIDX_W'(slot);
          r.new_generation = slot_gen[slot];
        end
      end
      REQ_DESTROY: begin
        if (handle_live(idx, gen) && free_depth < POOL_SIZE) begin
          slot_live[idx]         = 1'b0;
          free_slots[free_depth] = idx;
          free_depth++;
          if (live_count > 0) live_count--;
          r.status = ST_OK;
        end
      end
      REQ_CHECK: begin
        if (handle_live(idx, gen)) r.status = ST_OK;
      end
      default: ;
    endcase
    r.living_count = COUNT_W'(live_count);
    r.pool_full    = (live_count == POOL_SIZE);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        free_slots[i] = i;
        slot_gen[i]   = '0;
        slot_live[i]  = 1'b0;
      end
      free_depth    = POOL_SIZE;
      live_count    = 0;
      awaited_q.delete();
      pending_o     = 0;
      error_count_o = 0;
    end else begin
      // request first, so a same-edge response still pops the oldest one
      if (req_i.valid && req_i.ready)
        awaited_q.insert(awaited_q.size(),
                         resolve_request(req_i.req_type, req_i.handle_index,
                                         req_i.handle_generation));
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_q.size() == 0) begin
          flag_error("response transfer with no request outstanding");
        end else begin
          want = awaited_q.pop_front();
          check_field("status", 64'(rsp_i.status), 64'(want.status));
          check_field("new_index", 64'(rsp_i.new_index), 64'(want.new_index));
          check_field("new_generation", 64'(rsp_i.new_generation),
                      64'(want.new_generation));
          check_field("living_count", 64'(rsp_i.living_count), 64'(want.living_count));
          check_field("pool_full", 64'(rsp_i.pool_full), 64'(want.pool_full));
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ----- tb/tb_generational_handle_allocator.sv -----
`timescale 1ns / 100ps
// testbench top for the handle allocator: clock, reset, stimulus, back-pressure, verdict
module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int unsigned POOL       = POOL_SIZE_DEF;
  localparam int unsigned MIXED_N    = 300;   // transfers in the balanced phase
  localparam int unsigned TARGET_N   = 1650;  // rough total of counted requests
  localparam int unsigned SENT_CAP   = 2000;  // hard stop for the filling phase
  localparam int unsigned OVERFULL_N = 40;    // requests kept up after the pool is seen full
  localparam int unsigned DRAIN_MIN  = 150;
  localparam int unsigned TAIL_CYC   = 20;    // quiet cycles after the last response

  // code 3 is not a request; the block must answer it as invalid
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [HIDX_W-1:0] idx;
    logic [HGEN_W-1:0] gen;
  } handle_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned error_count;
  int unsigned pending;

  // handles learnt from responses (live) and handles already given back (stale)
  handle_t     live_handles [$];
  handle_t     dead_handles [$];
  bit          full_seen;
  int unsigned sent;
  int unsigned burst_left;

  gha_req_if req_if ();
  gha_rsp_if rsp_if ();

  generational_handle_allocator #(
    .POOL_SIZE (POOL),
    .GEN_BITS  (GEN_BITS_DEF)
  ) dut (
    .clk_i,
    .rst_ni,
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  gha_handle_checker #(
    .POOL_SIZE (POOL),
    .GEN_BITS  (GEN_BITS_DEF)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // runaway guard, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // learn created handles from the response channel; sampled on the falling edge
  // so the stimulus process never races with it
  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_if.pool_full) full_seen = 1'b1;
      if (rsp_if.status == ST_OK && rsp_if.new_generation != '0)
        live_handles.insert(live_handles.size(),
                            '{idx: HIDX_W'(rsp_if.new_index),
                              gen: rsp_if.new_generation});
    end
  end

  // sender gap: mostly none, some short, a few long, and now and then a
  // burst of back-to-back transfers
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      burst_left = $urandom_range(80, 30);
      return 0;
    end
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one request transfer; returns at the edge where it was taken, valid still high
  task automatic send_req(input logic [REQ_W-1:0]  kind,
                          input logic [HIDX_W-1:0] idx,
                          input logic [HGEN_W-1:0] gen);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid             <= 1'b1;
    req_if.req_type          <= kind;
    req_if.handle_index      <= idx;
    req_if.handle_generation <= gen;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind != REQ_UNUSED) sent++;
  endtask

  // hold the sender until every outstanding response has been transferred
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic handle_t take_live(input bit remove);
    int unsigned pick;
    handle_t     h;
    pick = $urandom_range(live_handles.size() - 1);
    h    = live_handles[pick];
    if (remove) begin
      live_handles.delete(pick);
      dead_handles.insert(dead_handles.size(), h);
      if (dead_handles.size() > 64) void'(dead_handles.pop_front());
    end
    return h;
  endfunction

  // malformed traffic: random codes, stale handles, corrupted generations,
  // indices past the pool
  task automatic send_broken();
    handle_t          h;
    logic [REQ_W-1:0] kind;
    kind = $urandom_range(1) ? REQ_DESTROY : REQ_CHECK;
    case ($urandom_range(4))
      0: send_req(REQ_W'($urandom_range(3)), HIDX_W'($urandom), $urandom);
      1: begin
        if (dead_handles.size() > 0) begin
          h = dead_handles[$urandom_range(dead_handles.size() - 1)];
          send_req(kind, h.idx, h.gen);
        end else begin
          send_req(kind, HIDX_W'($urandom_range(POOL - 1)), 0);
        end
      end
      2: begin
        if (live_handles.size() > 0) begin
          h = take_live(1'b0);
          send_req(kind, h.idx, h.gen ^ (32'd1 << $urandom_range(31)));
        end else begin
          send_req(kind, HIDX_W'($urandom), $urandom);
        end
      end
      3: send_req(kind, HIDX_W'(POOL + $urandom_range(65535 - POOL)), $urandom_range(3));
      default: begin
        if (live_handles.size() > 0) begin
          h = take_live(1'b0);
          send_req(REQ_UNUSED, h.idx, h.gen);
        end else begin
          send_req(REQ_UNUSED, HIDX_W'($urandom), $urandom);
        end
      end
    endcase
  endtask

  // weighted random request; whatever is left after the three shares is noise
  task automatic send_random(input int unsigned pct_create, input int unsigned pct_destroy,
                             input int unsigned pct_check);
    int unsigned roll;
    handle_t     h;
    roll = $urandom_range(99);
    if (roll < pct_create) begin
      // payload of a create is don't-care; randomise it to toggle every bit
      send_req(REQ_CREATE, HIDX_W'($urandom), $urandom);
    end else if (roll < pct_create + pct_destroy) begin
      if (live_handles.size() > 0) begin
        h = take_live(1'b1);
        send_req(REQ_DESTROY, h.idx, h.gen);
      end else begin
        send_req(REQ_DESTROY, HIDX_W'($urandom_range(POOL - 1)), $urandom_range(3));
      end
    end else if (roll < pct_create + pct_destroy + pct_check) begin
      if (live_handles.size() > 0 && $urandom_range(3) != 0) begin
        h = take_live(1'b0);
        send_req(REQ_CHECK, h.idx, h.gen);
      end else begin
        send_req(REQ_CHECK, HIDX_W'($urandom_range(POOL - 1)), $urandom_range(4));
      end
    end else begin
      send_broken();
    end
  endtask

  // response back-pressure: short and long stalls, with long stretches of ready
  initial begin
    int unsigned roll;
    int unsigned stall;
    int unsigned run;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      roll  = $urandom_range(99);
      stall = (roll < 50) ? 0 : (roll < 92) ? $urandom_range(3, 1) : $urandom_range(60, 15);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      run = ($urandom_range(99) < 5) ? $urandom_range(300, 100) : $urandom_range(6, 1);
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned extra;
    int unsigned drained;
    req_if.valid             <= 1'b0;
    req_if.req_type          <= REQ_CREATE;
    req_if.handle_index      <= '0;
    req_if.handle_generation <= '0;
    rst_ni                   <= 1'b0;
    full_seen  = 1'b0;
    sent       = 0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fresh pool, LIFO reuse, stale and wrong generations, out of range
    send_req(REQ_CHECK, '0, 0);                          // never-created slot
    send_req(REQ_DESTROY, '0, 0);                        // destroy of a dead slot is refused
    send_req(REQ_CREATE, '1, '1);                        // first pop: top slot, generation one
    send_req(REQ_CREATE, '0, 0);
    send_req(REQ_CREATE, '0, 0);
    send_req(REQ_CHECK, HIDX_W'(POOL - 1), 1);           // live handle
    send_req(REQ_CHECK, HIDX_W'(POOL - 1), 2);           // wrong generation
    send_req(REQ_CHECK, HIDX_W'(POOL - 1), '1);          // all-ones generation
    send_req(REQ_CHECK, '1, 1);                          // highest index
    send_req(REQ_CHECK, HIDX_W'(POOL), 0);               // first index past the pool
    send_req(REQ_DESTROY, HIDX_W'(POOL - 2), 1);
    send_req(REQ_DESTROY, HIDX_W'(POOL - 2), 1);         // double destroy
    send_req(REQ_CHECK, HIDX_W'(POOL - 2), 1);
    send_req(REQ_CREATE, '0, 0);                         // same slot back, generation two
    send_req(REQ_CHECK, HIDX_W'(POOL - 2), 1);           // stale handle
    send_req(REQ_CHECK, HIDX_W'(POOL - 2), 2);
    send_req(REQ_UNUSED, HIDX_W'(POOL - 3), 1);          // unused code must change nothing
    send_req(REQ_CHECK, HIDX_W'(POOL - 3), 1);
    send_req(REQ_DESTROY, '1, 0);                        // destroy past the pool
    send_req(REQ_DESTROY, HIDX_W'(POOL - 1), 1);
    send_req(REQ_DESTROY, HIDX_W'(POOL - 3), 1);
    send_req(REQ_DESTROY, HIDX_W'(POOL - 2), 2);
    send_req(REQ_CHECK, '0, '0);

    // everything from the directed part is dead again; start the lists afresh
    quiesce();
    live_handles.delete();
    dead_handles.delete();

    // balanced traffic around a small population
    for (int i = 0; i < MIXED_N; i++) send_random(40, 30, 20);
    quiesce();

    // fill the pool, then keep pushing creates against the full pool
    extra = 0;
    while (extra < OVERFULL_N && sent < SENT_CAP) begin
      send_random(90, 3, 5);
      if (full_seen) extra++;
    end

    // drain back down
    drained = 0;
    while (sent < TARGET_N || drained < DRAIN_MIN) begin
      send_random(15, 70, 10);
      drained++;
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
